FILE: rtl/xsx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package xsx_pkg;

  // framing, identity and mode bytes
  localparam logic [7:0] SOX_BYTE      = 8'hF0;
  localparam logic [7:0] EOX_BYTE      = 8'hF7;
  localparam logic [7:0] MAKER_ID      = 8'h43;
  localparam logic [7:0] MODEL_ID_A    = 8'h4C;
  localparam logic [7:0] MODEL_ID_B    = 8'h4B;
  localparam logic [7:0] MODE_MASK     = 8'h70;
  localparam logic [7:0] MODE_NIB_BULK = 8'h00;
  localparam logic [7:0] MODE_NIB_PARM = 8'h10;

  localparam logic [13:0] MAX_PAYLOAD_BYTES = 14'd16383;
  localparam logic [14:0] POS_MAX           = 15'h7FFF;

  // verdict status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FRAMING  = 3'd1;
  localparam logic [2:0] ST_MAKER    = 3'd2;
  localparam logic [2:0] ST_MODEL    = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;
  localparam logic [2:0] ST_LENGTH   = 3'd5;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } xsx_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [6:0]  payload_byte;
    logic [13:0] payload_offset;
    logic        accepted;
    logic [2:0]  status_code;
    logic        is_bulk_dump;
    logic [6:0]  address_high;
    logic [6:0]  address_mid;
    logic [6:0]  address_low;
    logic [13:0] payload_count;
  } xsx_out_t;

endpackage
`default_nettype wire

FILE: rtl/xsx_front.sv
`timescale 1ns / 1ps
`default_nettype none
module xsx_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire xsx_pkg::xsx_in_t in_data,
  input  wire logic             queue_full,
  output logic                  push,
  output xsx_pkg::xsx_out_t     push_data
);
  import xsx_pkg::*;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_BULK  = 2'd1;
  localparam logic [1:0] MODE_PARAM = 2'd2;
  localparam logic [1:0] MODE_REJ   = 2'd3;

  logic [14:0] pos, pos_next;
  logic [1:0]  mode, mode_next;
  logic [2:0]  err, err_next;
  logic [13:0] bulk_size, bulk_size_next;
  logic [6:0]  sum, sum_next;
  logic [6:0]  key_high, key_high_next;
  logic [6:0]  key_mid, key_mid_next;
  logic [6:0]  key_low, key_low_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        held_valid, held_valid_next;
  logic [13:0] count, count_next;

  logic        accept;
  logic [7:0]  b;
  logic [6:0]  b7;
  logic [14:0] bulk_p9;
  logic [14:0] bulk_p10;
  logic [6:0]  chk_expect;
  logic [2:0]  st;
  logic        emit_req;
  logic [14:0] emit_off;

  assign in_stall   = queue_full;
  assign accept     = in_valid && !queue_full;
  assign b          = in_data.data_byte;
  assign b7         = in_data.data_byte[6:0];
  assign bulk_p9    = {1'b0, bulk_size} + 15'd9;
  assign bulk_p10   = {1'b0, bulk_size} + 15'd10;
  assign chk_expect = 7'(7'd0 - sum);

  always_comb begin
    pos_next        = pos;
    mode_next       = mode;
    err_next        = err;
    bulk_size_next  = bulk_size;
    sum_next        = sum;
    key_high_next   = key_high;
    key_mid_next    = key_mid;
    key_low_next    = key_low;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    count_next      = count;
    push            = 1'b0;
    emit_req        = 1'b0;
    emit_off        = '0;
    st              = ST_OK;

    push_data                = '0;
    push_data.is_bulk_dump   = (mode == MODE_BULK);
    push_data.address_high   = key_high;
    push_data.address_mid    = key_mid;
    push_data.address_low    = key_low;

    if (accept) begin
      if (in_data.end_of_message) begin
        if (pos == 15'd0 || b != EOX_BYTE) begin
          st = ST_FRAMING;
        end else if (err != ST_OK) begin
          st = err;
        end else if (mode == MODE_PARAM) begin
          st = (pos < 15'd7) ? ST_LENGTH : ST_OK;
        end else if (mode == MODE_BULK) begin
          if (pos != bulk_p10 || !held_valid) begin
            st = ST_LENGTH;
          end else if (held_byte != {1'b0, chk_expect}) begin
            st = ST_CHECKSUM;
          end else begin
            st = ST_OK;
          end
        end else begin
          st = ST_LENGTH;
        end
        push                    = 1'b1;
        push_data.result_kind   = KIND_VERDICT;
        push_data.accepted      = (st == ST_OK);
        push_data.status_code   = st;
        push_data.payload_count = count;
        // rearm for the next message
        pos_next        = '0;
        mode_next       = MODE_NONE;
        err_next        = ST_OK;
        bulk_size_next  = '0;
        sum_next        = '0;
        key_high_next   = '0;
        key_mid_next    = '0;
        key_low_next    = '0;
        held_byte_next  = '0;
        held_valid_next = 1'b0;
        count_next      = '0;
      end else begin
        case (pos)
          15'd0: begin
            if (b != SOX_BYTE && err == ST_OK) err_next = ST_FRAMING;
          end
          15'd1: begin
            if (b != MAKER_ID && err == ST_OK) err_next = ST_MAKER;
          end
          15'd2: begin
            if ((b & MODE_MASK) == MODE_NIB_BULK) begin
              mode_next = MODE_BULK;
            end else if ((b & MODE_MASK) == MODE_NIB_PARM) begin
              mode_next = MODE_PARAM;
            end else begin
              mode_next = MODE_REJ;
              if (err == ST_OK) err_next = ST_MODEL;
            end
          end
          15'd3: begin
            if (b != MODEL_ID_A && b != MODEL_ID_B && err == ST_OK) err_next = ST_MODEL;
          end
          default: begin
            if (mode == MODE_BULK) begin
              if (pos < 15'd9) begin
                sum_next = sum + b7;
                case (pos)
                  15'd4:   bulk_size_next = {b7, 7'd0};
                  15'd5:   bulk_size_next = {bulk_size[13:7], b7};
                  15'd6:   key_high_next  = b7;
                  15'd7:   key_mid_next   = b7;
                  default: key_low_next   = b7;
                endcase
              end else if (pos < bulk_p9) begin
                sum_next = sum + b7;
                emit_req = 1'b1;
                emit_off = pos - 15'd9;
              end else if (pos == bulk_p9) begin
                held_byte_next  = b;
                held_valid_next = 1'b1;
              end else begin
                if (err == ST_OK) err_next = ST_LENGTH;
              end
            end else if (mode == MODE_PARAM) begin
              case (pos)
                15'd4: key_high_next = b7;
                15'd5: key_mid_next  = b7;
                15'd6: key_low_next  = b7;
                default: begin
                  emit_req = 1'b1;
                  emit_off = pos - 15'd7;
                end
              endcase
            end
          end
        endcase

        // payload beats stop once any error is on record
        if (emit_req && err == ST_OK) begin
          if (count >= MAX_PAYLOAD_BYTES) begin
            err_next = ST_LENGTH;
          end else begin
            push                     = 1'b1;
            push_data.result_kind    = KIND_PAYLOAD;
            push_data.payload_byte   = b7;
            push_data.payload_offset = emit_off[13:0];
            count_next               = count + 14'd1;
          end
        end

        if (pos != POS_MAX) pos_next = pos + 15'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      mode       <= MODE_NONE;
      err        <= ST_OK;
      bulk_size  <= '0;
      sum        <= '0;
      key_high   <= '0;
      key_mid    <= '0;
      key_low    <= '0;
      held_byte  <= '0;
      held_valid <= 1'b0;
      count      <= '0;
    end else begin
      pos        <= pos_next;
      mode       <= mode_next;
      err        <= err_next;
      bulk_size  <= bulk_size_next;
      sum        <= sum_next;
      key_high   <= key_high_next;
      key_mid    <= key_mid_next;
      key_low    <= key_low_next;
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
      count      <= count_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/xsx_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module xsx_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire xsx_pkg::xsx_out_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output xsx_pkg::xsx_out_t      out_data
);
  import xsx_pkg::*;

  xsx_out_t    mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  fill;
  logic        pop;
  logic        do_push;

  assign full      = (fill == 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (pop)     rd_ptr <= !rd_ptr;
      case ({do_push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/xg_sysex_message_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// result path: a result beat is written into the queue register and shows on res_valid from there
// throughput: one byte per cycle while the queue is not full, set by the parser update in the front end
// the two-entry result queue stalls the byte side only when it holds two unread beats
// reset: synchronous, clears the parser state and empties the queue; no clearing pass
module xg_sysex_message_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             byte_valid,
  output logic                  byte_stall,
  input  wire xsx_pkg::xsx_in_t byte_data,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output xsx_pkg::xsx_out_t     res_data
);
  import xsx_pkg::*;

  // beat from the parser into the queue
  logic     push;
  xsx_out_t push_data;
  logic     queue_full;

  // front end: framing, identity and mode checks, address capture,
  // checksum accumulation, length checks and payload/verdict beat generation
  xsx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (byte_valid),
    .in_stall   (byte_stall),
    .in_data    (byte_data),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // back end: result queue, holds beats steady while the consumer stalls
  xsx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .out_data  (res_data)
  );

endmodule
`default_nettype wire
